/* sv/paged_register_access_sequencer_core_defines.svh */
// Assertion macros used by the paged register access sequencer back end.
`ifndef PAGED_REGISTER_ACCESS_SEQUENCER_CORE_DEFINES_SVH
`define PAGED_REGISTER_ACCESS_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PRAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pras: immediate implication violated");
`define PRAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pras: next-cycle implication violated");
`else
`define PRAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PRAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/pras_pkg.sv */
// Types and constants shared by the paged register access sequencer.
`timescale 1ns / 1ps
package pras_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_RAW    = 2'd2;

    localparam logic [6:0] PAGE_SELECT = 7'h00;
    localparam logic [6:0] BOOK_SELECT = 7'h7F;

    localparam logic REG_DEVICE_ADDRESS = 1'b0;

    typedef struct packed {
        logic [1:0]  command;
        logic [22:0] flat_address;
        logic [6:0]  raw_offset;
        logic [7:0]  data_value;
        logic [7:0]  bit_mask;
        logic [7:0]  readback_value;
        logic        table_last;
    } t_in_item;

    typedef struct packed {
        logic [6:0] bus_address;
        logic [6:0] bus_register;
        logic [7:0] bus_data;
        logic       is_read;
        logic       last_of_run;
    } t_result;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_READ_WRITE
    } t_op;

    typedef enum logic [2:0] {
        STEP_PAGE0,
        STEP_BOOK,
        STEP_PAGE,
        STEP_MAIN,
        STEP_WRITEBACK
    } t_step;

    typedef struct packed {
        logic       sel_book;
        logic [7:0] book;
        logic       sel_page;
        logic [7:0] page;
        logic [6:0] reg_offset;
        logic [7:0] data;
        t_op        op;
    } t_plan;

endpackage

/* sv/paged_register_access_sequencer_core.sv */
// Top level of the paged register access sequencer with its configuration port.
//
// Usage: an access item enters on i_valid/o_ready with payload i_item. Each
// item is turned into zero to five bus transactions, delivered one per
// transaction on o_valid/i_ready with payload o_result; the final one of an
// item carries last_of_run. Paged writes and updates emit book and page
// select writes only when the cached selection changes.
// The first transaction of an accepted item passes through the plan queue and
// the output register. Throughput: one transaction per cycle while the
// receiver does not stall; an item's sequencer time is set by the number of
// transactions its plan holds. Items that yield nothing are dropped at accept
// and take no sequencer time. A two-entry plan queue lets the front end keep
// accepting while the sequencer works or the receiver stalls.
// When the receiver stalls, the output register holds its transaction and the
// queue fills; o_ready drops once both queue entries are in use.
// Reset clears the cached book and page, the device address, the queue and
// the output valid flag. The device address is written over the APB port at
// byte address 0 and should only change while the block is idle.
`timescale 1ns / 1ps
module paged_register_access_sequencer_core import pras_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] r_device_address;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_q_valid;
    t_plan      w_plan;
    t_plan      w_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? {25'd0, r_device_address} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= 7'd0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEVICE_ADDRESS) begin
            r_device_address <= pwdata[6:0];
        end
    end

    pras_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (i_item),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_plan       (w_plan)
    );

    pras_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_plan  (w_plan),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    pras_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .i_device_address (r_device_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result         (o_result)
    );

endmodule

/* sv/pras_front.sv */
// Front end: accepts items, tracks the cached book and page, and builds a transaction plan.
`timescale 1ns / 1ps
module pras_front import pras_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_queue_full,
    output logic     o_push,
    output t_plan    o_plan
);

    logic [7:0] r_book;
    logic [7:0] r_page;
    logic [7:0] n_book;
    logic [7:0] n_page;
    logic [7:0] w_book;
    logic [7:0] w_page;
    logic [7:0] w_merged;
    logic       w_keep;
    logic       w_accept;
    t_plan      w_plan;

    assign w_book   = i_item.flat_address[22:15];
    assign w_page   = i_item.flat_address[14:7];
    assign w_merged = (i_item.readback_value & ~i_item.bit_mask)
                    | (i_item.data_value & i_item.bit_mask);

    always_comb begin
        n_book = r_book;
        n_page = r_page;
        w_keep = 1'b0;
        w_plan = '0;
        unique case (i_item.command)
            CMD_WRITE, CMD_UPDATE: begin
                w_keep            = 1'b1;
                w_plan.sel_book   = (w_book != r_book);
                w_plan.sel_page   = (w_book != r_book) ? (w_page != 8'h00) : (w_page != r_page);
                w_plan.book       = w_book;
                w_plan.page       = w_page;
                w_plan.reg_offset = i_item.flat_address[6:0];
                n_book            = w_book;
                n_page            = w_page;
                if (i_item.command == CMD_WRITE) begin
                    w_plan.op   = OP_WRITE;
                    w_plan.data = i_item.data_value;
                end else if (w_merged == i_item.readback_value) begin
                    w_plan.op   = OP_READ;
                    w_plan.data = 8'h00;
                end else begin
                    w_plan.op   = OP_READ_WRITE;
                    w_plan.data = w_merged;
                end
            end
            CMD_RAW: begin
                w_keep            = 1'b1;
                w_plan.op         = OP_WRITE;
                w_plan.reg_offset = i_item.raw_offset;
                w_plan.data       = i_item.data_value;
                priority if (i_item.raw_offset == PAGE_SELECT) begin
                    if (i_item.data_value == r_page) begin
                        w_keep = 1'b0;
                    end else begin
                        n_page = i_item.data_value;
                    end
                end else if (r_page == 8'h00 && i_item.raw_offset == BOOK_SELECT) begin
                    if (i_item.data_value == r_book) begin
                        w_keep = 1'b0;
                    end else begin
                        n_book = i_item.data_value;
                    end
                end else begin
                    w_keep = 1'b1;
                end
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && w_keep;
    assign o_plan   = w_plan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_book <= 8'h00;
            r_page <= 8'h00;
        end else if (w_accept) begin
            r_book <= n_book;
            r_page <= n_page;
        end
    end

endmodule

/* sv/pras_queue.sv */
// Two-entry plan queue between the front end and the transaction sequencer.
`timescale 1ns / 1ps
module pras_queue import pras_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_plan i_plan,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_plan o_head
);

    t_plan      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

/* sv/pras_back.sv */
// Back end: steps through each plan and emits one bus transaction per cycle while the receiver does not stall.
`timescale 1ns / 1ps
`include "paged_register_access_sequencer_core_defines.svh"
module pras_back import pras_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_plan      i_head,
    output logic       o_pop,
    input  logic [6:0] i_device_address,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_result
);

    logic    r_active;
    t_step   r_step;
    t_step   n_step;
    t_step   w_cur;
    logic    w_last;
    logic    w_load;
    logic    r_out_valid;
    t_result r_out;
    t_result w_txn;

    always_comb begin
        if (r_active) begin
            w_cur = r_step;
        end else if (i_head.sel_book) begin
            w_cur = STEP_PAGE0;
        end else if (i_head.sel_page) begin
            w_cur = STEP_PAGE;
        end else begin
            w_cur = STEP_MAIN;
        end
    end

    always_comb begin
        n_step = STEP_MAIN;
        unique case (w_cur)
            STEP_PAGE0: n_step = STEP_BOOK;
            STEP_BOOK:  n_step = i_head.sel_page ? STEP_PAGE : STEP_MAIN;
            STEP_PAGE:  n_step = STEP_MAIN;
            STEP_MAIN:  n_step = STEP_WRITEBACK;
            default:    n_step = STEP_MAIN;
        endcase
    end

    always_comb begin
        w_txn             = '0;
        w_txn.bus_address = i_device_address;
        w_last            = 1'b0;
        unique case (w_cur)
            STEP_PAGE0: begin
                w_txn.bus_register = PAGE_SELECT;
            end
            STEP_BOOK: begin
                w_txn.bus_register = BOOK_SELECT;
                w_txn.bus_data     = i_head.book;
            end
            STEP_PAGE: begin
                w_txn.bus_register = PAGE_SELECT;
                w_txn.bus_data     = i_head.page;
            end
            STEP_MAIN: begin
                w_txn.bus_register = i_head.reg_offset;
                w_txn.bus_data     = (i_head.op == OP_WRITE) ? i_head.data : 8'h00;
                w_txn.is_read      = (i_head.op != OP_WRITE);
                w_last             = (i_head.op != OP_READ_WRITE);
            end
            default: begin
                w_txn.bus_register = i_head.reg_offset;
                w_txn.bus_data     = i_head.data;
                w_last             = 1'b1;
            end
        endcase
        w_txn.last_of_run = w_last;
    end

    assign w_load   = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop    = w_load && w_last;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_txn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_step      <= STEP_MAIN;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_active    <= !w_last;
                r_step      <= n_step;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `PRAS_ASSERT_NEXT(a_pop_gives_last, i_clk, i_rst_n, o_pop, r_out_valid && r_out.last_of_run)
    `PRAS_ASSERT_IMPLY(a_active_has_head, i_clk, i_rst_n, r_active, i_q_valid)
    `PRAS_ASSERT_IMPLY(a_page0_only_first, i_clk, i_rst_n, r_active, r_step != STEP_PAGE0)

endmodule
